// ===== rtl/core/psu_pkg.sv =====
`timescale 1ns / 1ps

package psu_pkg;

  // Longest scanline the LED counter can address
  localparam int unsigned MAX_LEDS    = 256;
  localparam int unsigned TABLE_DEPTH = 256;

  localparam logic [7:0] LOW_NIBBLE = 8'h0F;

  // image_format codes
  localparam logic [1:0] FMT_ONE_BIT   = 2'd0;
  localparam logic [1:0] FMT_FOUR_BIT  = 2'd1;
  localparam logic [1:0] FMT_EIGHT_BIT = 2'd2;
  localparam logic [1:0] FMT_TRUECOLOR = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_IMAGE_FORMAT  = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT    = 2'd1;
  localparam logic [1:0] REG_LEDS_PER_LINE = 2'd2;

  // input item mode
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_IMAGE   = 1'b1;

  // truecolor gather phase
  localparam logic [1:0] PHASE_RED   = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_BLUE  = 2'd2;

  localparam int unsigned CFG_AW = 4;

  typedef struct packed {
    logic       mode;
    logic [7:0] palette_slot;
    logic [7:0] slot_red;
    logic [7:0] slot_green;
    logic [7:0] slot_blue;
    logic [7:0] data_byte;
  } psu_in_t;

  typedef struct packed {
    logic [7:0]  led_position;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] scanline;
    logic        line_done;
    logic        run_last;
  } psu_out_t;

  // Pixel context riding alongside the palette read
  typedef struct packed {
    logic [7:0]  led_position;
    logic [15:0] scanline;
    logic        line_done;
    logic        run_last;
    logic        direct;
    logic        out_of_range;
    logic [23:0] rgb;
  } psu_meta_t;

endpackage

// ===== rtl/core/psu_stream_if.sv =====
`timescale 1ns / 1ps

interface psu_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/palette_scanline_pixel_unpacker_unit.sv =====
`timescale 1ns / 1ps

// Path: an image byte goes into the byte register, then the table read stage, then the output register.
// Throughput: one result per cycle unless the output stalls; a byte gives up to 8 results (1-bit),
//   2 (4-bit), 1 (8-bit). The single colour table read port, one read per result, sets the rate.
// Palette writes and truecolor R/G bytes produce nothing.
// Reset: counters, truecolor phase and configuration registers return to defaults; the
// colour table is not cleared and holds undefined data until written.

module palette_scanline_pixel_unpacker_unit #(
  parameter int unsigned TableDepth = psu_pkg::TABLE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  psu_stream_if.sink                 in_i,
  psu_stream_if.source               out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [psu_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import psu_pkg::*;

  localparam int unsigned Aw = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]  fmt_q;
  logic [15:0] line_count_q;
  logic [8:0]  lpl_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= FMT_ONE_BIT;
      line_count_q <= 16'd1;
      lpl_q        <= 9'd78;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_FORMAT:  fmt_q        <= pwdata[1:0];
        REG_LINE_COUNT:    line_count_q <= pwdata[15:0];
        REG_LEDS_PER_LINE: lpl_q        <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_FORMAT:  prdata = {30'd0, fmt_q};
      REG_LINE_COUNT:    prdata = {16'd0, line_count_q};
      REG_LEDS_PER_LINE: prdata = {23'd0, lpl_q};
      default:           prdata = 32'd0;
    endcase
  end

  // Effective line length: 0 acts as 1, clamp at MAX_LEDS
  logic [8:0] line_len;
  always_comb begin
    if (lpl_q == 9'd0) begin
      line_len = 9'd1;
    end else if (lpl_q > 9'(MAX_LEDS)) begin
      line_len = 9'(MAX_LEDS);
    end else begin
      line_len = lpl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Unpacker: holds the current byte and, when not stalled, issues one table read per cycle
  // ---------------------------------------------------------------------------
  logic        busy_q, busy_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [23:0] rgb_q, rgb_d;     // truecolor pixel, bypasses the table
  logic [15:0] held_q, held_d;   // gathered red (high) and green (low)
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  led_q, led_d;
  logic [15:0] line_q, line_d;

  logic        s2_valid_q;
  psu_meta_t   s2_meta_q;
  logic        out_valid_q;
  psu_out_t    out_data_q;

  logic        s2_adv, issue, issue_last, line_end, in_ready, in_fire;
  logic [7:0]  idx;
  logic        oor;
  logic [15:0] line_inc;
  logic [23:0] ram_rdata;
  logic        ram_we;

  assign s2_adv   = !out_valid_q || out_o.ready;
  assign issue    = busy_q && (!s2_valid_q || s2_adv);
  assign line_end = ({1'b0, led_q} + 9'd1) >= line_len;
  assign line_inc = line_q + 16'd1;

  always_comb begin
    case (fmt_q)
      FMT_ONE_BIT: begin
        issue_last = (cnt_q == 3'd7) || line_end;
        idx        = {7'd0, byte_q[cnt_q]};
      end
      FMT_FOUR_BIT: begin
        // high nibble first
        issue_last = cnt_q[0] || line_end;
        idx        = cnt_q[0] ? (byte_q & LOW_NIBBLE) : (byte_q >> 4);
      end
      default: begin
        issue_last = 1'b1;
        idx        = byte_q;
      end
    endcase
  end

  assign oor      = {1'b0, idx} >= 9'(TableDepth);
  // next byte may enter as the current one issues its last read
  assign in_ready = !busy_q || (issue && issue_last);
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign ram_we = in_fire && (in_i.data.mode == MODE_PALETTE)
               && ({1'b0, in_i.data.palette_slot} < 9'(TableDepth));

  always_comb begin
    busy_d  = busy_q;
    byte_d  = byte_q;
    cnt_d   = cnt_q;
    rgb_d   = rgb_q;
    held_d  = held_q;
    phase_d = phase_q;
    led_d   = led_q;
    line_d  = line_q;

    if (issue) begin
      cnt_d = cnt_q + 3'd1;
      if (issue_last) begin
        busy_d = 1'b0;
      end
      if (line_end) begin
        led_d  = 8'd0;
        line_d = (line_inc >= line_count_q) ? 16'd0 : line_inc;
      end else begin
        led_d = led_q + 8'd1;
      end
    end

    if (in_fire && (in_i.data.mode == MODE_IMAGE)) begin
      if (fmt_q == FMT_TRUECOLOR) begin
        case (phase_q)
          PHASE_RED: begin
            held_d[15:8] = in_i.data.data_byte;
            phase_d      = PHASE_GREEN;
          end
          PHASE_GREEN: begin
            held_d[7:0] = in_i.data.data_byte;
            phase_d     = PHASE_BLUE;
          end
          default: begin
            rgb_d   = {held_q, in_i.data.data_byte};
            phase_d = PHASE_RED;
            busy_d  = 1'b1;
            cnt_d   = 3'd0;
          end
        endcase
      end else begin
        busy_d = 1'b1;
        byte_d = in_i.data.data_byte;
        cnt_d  = 3'd0;
      end
    end

    // format change restarts the truecolor gather
    if (cfg_wr && (cfg_idx == REG_IMAGE_FORMAT)) begin
      phase_d = PHASE_RED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= 3'd0;
      held_q  <= 16'd0;
      phase_q <= PHASE_RED;
      led_q   <= 8'd0;
      line_q  <= 16'd0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
      phase_q <= phase_d;
      led_q   <= led_d;
      line_q  <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rgb_q  <= rgb_d;
  end

  // ---------------------------------------------------------------------------
  // Colour table
  // ---------------------------------------------------------------------------
  psu_ram #(
    .Width (24),
    .Depth (TableDepth)
  ) u_color_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.data.palette_slot[Aw-1:0]),
    .wdata_i ({in_i.data.slot_red, in_i.data.slot_green, in_i.data.slot_blue}),
    .re_i    (issue),
    .raddr_i (idx[Aw-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Read stage: pixel context waits alongside the table read
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (issue) begin
      s2_valid_q <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_meta_q.led_position <= led_q;
      s2_meta_q.scanline     <= line_q;
      s2_meta_q.line_done    <= line_end;
      s2_meta_q.run_last     <= issue_last;
      s2_meta_q.direct       <= (fmt_q == FMT_TRUECOLOR);
      s2_meta_q.out_of_range <= oor;
      s2_meta_q.rgb          <= rgb_q;
    end
  end

  logic [23:0] s2_color;
  always_comb begin
    if (s2_meta_q.direct) begin
      s2_color = s2_meta_q.rgb;
    end else if (s2_meta_q.out_of_range) begin
      s2_color = 24'd0;
    end else begin
      s2_color = ram_rdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_valid_q && s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_adv) begin
      out_data_q.led_position <= s2_meta_q.led_position;
      out_data_q.red          <= s2_color[23:16];
      out_data_q.green        <= s2_color[15:8];
      out_data_q.blue         <= s2_color[7:0];
      out_data_q.scanline     <= s2_meta_q.scanline;
      out_data_q.line_done    <= s2_meta_q.line_done;
      out_data_q.run_last     <= s2_meta_q.run_last;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== rtl/core/psu_ram.sv =====
`timescale 1ns / 1ps

module psu_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read-first: a read and a write to one entry in the same cycle return the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
